// ===== design/motor_speed_command_selector_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed command selector
// Shared helpers for concurrent assertions with a clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_COMMAND_SELECTOR_ASSERT_SVH
`define MOTOR_SPEED_COMMAND_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define MSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define MSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Types, codes and constants of the motor speed command selector.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Item kinds
  localparam logic [1:0] KindCmd    = 2'd0;
  localparam logic [1:0] KindTick   = 2'd1;
  localparam logic [1:0] KindSample = 2'd2;

  // Command characters
  localparam logic [7:0] CmdManual  = 8'h30;  // '0'
  localparam logic [7:0] CmdDist    = 8'h31;  // '1'
  localparam logic [7:0] CmdDigitLo = 8'h32;  // '2'
  localparam logic [7:0] CmdDigitHi = 8'h39;  // '9'
  localparam logic [7:0] CmdStopLo  = 8'h73;  // 's'
  localparam logic [7:0] CmdStopUp  = 8'h53;  // 'S'
  localparam logic [7:0] CmdOffLo   = 8'h78;  // 'x'
  localparam logic [7:0] CmdOffUp   = 8'h58;  // 'X'
  localparam logic [7:0] CmdOnLo    = 8'h72;  // 'r'
  localparam logic [7:0] CmdOnUp    = 8'h52;  // 'R'

  // Result causes
  localparam logic CauseStop = 1'b0;
  localparam logic CauseTick = 1'b1;

  localparam int unsigned EchoW = 15;
  localparam int unsigned PwmW  = 8;

  // distance_cm = floor(echo_us * SoundNum / SoundDen); dist >= d iff
  // echo >= ceil(d * SoundDen / SoundNum)
  localparam int unsigned SoundNum = 17;
  localparam int unsigned SoundDen = 1000;
  localparam logic [EchoW-1:0] EchoDist2   = EchoW'((2   * SoundDen + SoundNum - 1) / SoundNum);
  localparam logic [EchoW-1:0] EchoDist5   = EchoW'((5   * SoundDen + SoundNum - 1) / SoundNum);
  localparam logic [EchoW-1:0] EchoDist10  = EchoW'((10  * SoundDen + SoundNum - 1) / SoundNum);
  localparam logic [EchoW-1:0] EchoDist20  = EchoW'((20  * SoundDen + SoundNum - 1) / SoundNum);
  localparam logic [EchoW-1:0] EchoDist30  = EchoW'((30  * SoundDen + SoundNum - 1) / SoundNum);
  localparam logic [EchoW-1:0] EchoDist50  = EchoW'((50  * SoundDen + SoundNum - 1) / SoundNum);
  localparam logic [EchoW-1:0] EchoDist201 = EchoW'((201 * SoundDen + SoundNum - 1) / SoundNum);

  localparam logic [PwmW-1:0] PwmFull = 8'd255;
  localparam logic [PwmW-1:0] PwmHigh = 8'd200;
  localparam logic [PwmW-1:0] PwmMid  = 8'd150;
  localparam logic [PwmW-1:0] PwmLow  = 8'd100;
  localparam logic [PwmW-1:0] PwmMin  = 8'd50;
  localparam logic [PwmW-1:0] PwmOff  = 8'd0;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       command_byte;
    logic [EchoW-1:0] echo_us;
  } msc_in_t;

  typedef struct packed {
    logic [PwmW-1:0] pwm_value;
    logic            cause;
  } msc_out_t;

  typedef struct packed {
    logic     has_result;
    msc_out_t data;
  } msc_res_t;

  // floor(digit * 255 / 9) for digits 2..9
  function automatic logic [PwmW-1:0] manual_speed_lut(logic [3:0] digit);
    logic [PwmW-1:0] v;
    case (digit)
      4'd2:    v = 8'd56;
      4'd3:    v = 8'd85;
      4'd4:    v = 8'd113;
      4'd5:    v = 8'd141;
      4'd6:    v = 8'd170;
      4'd7:    v = 8'd198;
      4'd8:    v = 8'd226;
      4'd9:    v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/msc_echo_map.sv =====
// ----------------------------------------------------------------------------
// msc_echo_map
// Maps an echo time to a drive value through distance thresholds.
// ----------------------------------------------------------------------------
module msc_echo_map (
  input  logic [msc_pkg::EchoW-1:0] echo_us_i,
  output logic [msc_pkg::PwmW-1:0]  speed_o
);
  import msc_pkg::*;

  // thresholds are precomputed in echo time, so no divide is needed
  always_comb begin
    if (echo_us_i < EchoDist2 || echo_us_i >= EchoDist201) begin
      speed_o = PwmOff;
    end else if (echo_us_i >= EchoDist50) begin
      speed_o = PwmFull;
    end else if (echo_us_i >= EchoDist30) begin
      speed_o = PwmHigh;
    end else if (echo_us_i >= EchoDist20) begin
      speed_o = PwmMid;
    end else if (echo_us_i >= EchoDist10) begin
      speed_o = PwmLow;
    end else if (echo_us_i >= EchoDist5) begin
      speed_o = PwmMin;
    end else begin
      speed_o = PwmOff;
    end
  end

endmodule

// ===== design/msc_ctrl.sv =====
// ----------------------------------------------------------------------------
// msc_ctrl
// Mode, enable and speed state, and the result decision for one item.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msc_pkg::msc_in_t item_i,
  input  logic             fire_i,
  output msc_pkg::msc_res_t res_o
);
  import msc_pkg::*;

  logic            mode_q, mode_d;
  logic            active_q, active_d;
  logic [PwmW-1:0] manual_q, manual_d;
  logic            sent_vld_q, sent_vld_d;
  logic [PwmW-1:0] last_q, last_d;
  logic [PwmW-1:0] echo_speed;
  logic [PwmW-1:0] cand;
  logic            tick_use;

  msc_echo_map u_echo_map (
    .echo_us_i (item_i.echo_us),
    .speed_o   (echo_speed)
  );

  always_comb begin
    mode_d     = mode_q;
    active_d   = active_q;
    manual_d   = manual_q;
    sent_vld_d = sent_vld_q;
    last_d     = last_q;
    res_o      = '0;
    cand       = mode_q ? echo_speed : manual_q;
    // distance mode only reacts to sample ticks
    tick_use   = !mode_q || (item_i.kind == KindSample);

    if (item_i.kind == KindCmd) begin
      case (item_i.command_byte)
        CmdManual: begin
          mode_d                = 1'b0;
          res_o.has_result      = 1'b1;
          res_o.data.pwm_value  = PwmOff;
          res_o.data.cause      = CauseStop;
        end
        CmdDist: begin
          mode_d = 1'b1;
        end
        CmdStopLo, CmdStopUp: begin
          manual_d              = PwmOff;
          res_o.has_result      = 1'b1;
          res_o.data.pwm_value  = PwmOff;
          res_o.data.cause      = CauseStop;
        end
        CmdOffLo, CmdOffUp: begin
          active_d              = 1'b0;
          res_o.has_result      = 1'b1;
          res_o.data.pwm_value  = PwmOff;
          res_o.data.cause      = CauseStop;
        end
        CmdOnLo, CmdOnUp: begin
          active_d = 1'b1;
        end
        default: begin
          if (!mode_q && item_i.command_byte inside {[CmdDigitLo:CmdDigitHi]}) begin
            manual_d = manual_speed_lut(item_i.command_byte[3:0]);
          end
        end
      endcase
    end else if ((item_i.kind == KindTick || item_i.kind == KindSample) && active_q) begin
      if (tick_use && (!sent_vld_q || cand != last_q)) begin
        last_d               = cand;
        sent_vld_d           = 1'b1;
        res_o.has_result     = 1'b1;
        res_o.data.pwm_value = cand;
        res_o.data.cause     = CauseTick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      active_q   <= 1'b1;
      manual_q   <= '0;
      sent_vld_q <= 1'b0;
      last_q     <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      active_q   <= active_d;
      manual_q   <= manual_d;
      sent_vld_q <= sent_vld_d;
      last_q     <= last_d;
    end
  end

endmodule

// ===== design/motor_speed_command_selector.sv =====
// ----------------------------------------------------------------------------
// motor_speed_command_selector
// Turns command bytes and control ticks into motor drive values.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one command byte or
// tick per beat. Output channel (out_valid_o/out_ready_o/out_data_o) carries
// a drive value and its cause; an item gives zero or one output beat.
// An accepted beat sits in the input register until it advances, is decoded
// against the mode/speed state, and any result lands in the output register.
// Throughput is one item per cycle while no result meets a stalled output,
// set by the single decode step between the input and output registers.
// Reset empties both registers and returns to manual mode, enabled, manual
// speed 0, nothing sent. When the receiver stalls, the output register holds
// its beat; items that produce no result still drain past it, and the input
// side stalls only when an item with a result meets a full, stalled output.
// ----------------------------------------------------------------------------
module motor_speed_command_selector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msc_pkg::msc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output msc_pkg::msc_out_t out_data_o
);
  import msc_pkg::*;

  logic     in_valid_q;
  msc_in_t  in_data_q;
  logic     out_valid_q;
  msc_out_t out_data_q;
  msc_res_t res;
  logic     advance;

  // an item without a result never waits on the output register
  assign advance    = in_valid_q && (!res.has_result || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  msc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_data_q),
    .fire_i (advance),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && res.has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance && res.has_result) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/msc_checker.sv =====
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the motor speed command selector, bound to the top.
// ----------------------------------------------------------------------------
`include "motor_speed_command_selector_assert.svh"

module msc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input msc_pkg::msc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input msc_pkg::msc_out_t out_data_o
);
  import msc_pkg::*;

  // a stalled output beat holds
  `MSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))

  // a waiting input beat holds its payload
  `MSC_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_data_i))

  // forced stops always carry a zero drive value
  `MSC_ASSERT_NOW(a_stop_zero, clk_i, rst_ni,
    out_valid_o && out_data_o.cause == CauseStop, out_data_o.pwm_value == PwmOff)

  // input backpressure only comes from a full, stalled output register
  `MSC_ASSERT_NOW(a_ready_cause, clk_i, rst_ni, !in_ready_o,
    out_valid_o && !out_ready_i)

  // after a drain with no input, the input side is free again
  `MSC_ASSERT_NEXT(a_ready_free, clk_i, rst_ni,
    !in_valid_i && (!out_valid_o || out_ready_i), in_ready_o)

endmodule

bind motor_speed_command_selector msc_checker u_msc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
